[hw/rtl/dtoi_pkg.sv]
// ----------------------------------------------------------------------------
// dtoi_pkg: shared types and constants for the decimal text converter
// Character codes, parse phases, status codes, configuration register indexes
// and the magnitude limit function used by the configuration logic.
// ----------------------------------------------------------------------------
package dtoi_pkg;

	// Characters of interest
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Configuration register indexes
	localparam logic REG_WIDTH_SELECT = 1'b0;
	localparam logic REG_IS_SIGNED    = 1'b1;

	// Target width codes (anything else means 64 bits)
	localparam logic [1:0] WS_16 = 2'd0;
	localparam logic [1:0] WS_32 = 2'd1;

	typedef enum logic [2:0] {
		PH_LEAD  = 3'd0,
		PH_PLUS  = 3'd1,
		PH_MINUS = 3'd2,
		PH_DIGIT = 3'd3,
		PH_TRAIL = 3'd4,
		PH_JUNK  = 3'd5,
		PH_BAD   = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_RANGE   = 2'd2,
		ST_NOT_INT = 2'd3
	} status_t;

	// Configuration as seen by the parser
	typedef struct packed {
		logic        is_signed;
		logic [63:0] lim_pos;
		logic [63:0] lim_neg;
	} cfg_t;

	// One finished conversion
	typedef struct packed {
		logic [63:0] value;
		status_t     status;
	} result_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// Largest magnitude the target accepts for the given sign
	function automatic logic [63:0] mag_limit(input logic [1:0] ws, input logic sgn,
		input logic neg);
		logic [63:0] full;
		logic [63:0] half;
		case (ws)
			WS_16: begin
				full = 64'h0000_0000_0000_FFFF;
				half = 64'h0000_0000_0000_8000;
			end
			WS_32: begin
				full = 64'h0000_0000_FFFF_FFFF;
				half = 64'h0000_0000_8000_0000;
			end
			default: begin
				full = 64'hFFFF_FFFF_FFFF_FFFF;
				half = 64'h8000_0000_0000_0000;
			end
		endcase
		if (sgn) begin
			return neg ? half : (half - 64'd1);
		end
		return full;
	endfunction

endpackage

[hw/rtl/decimal_text_to_integer.sv]
// ----------------------------------------------------------------------------
// decimal_text_to_integer: decimal text to integer converter
// Streams characters in and gives the parsed value and status on the word
// marked last.
// ----------------------------------------------------------------------------
// The block takes one character word per clock and gives one result word for
// each word with tlast set: the accepted word is loaded into the input
// register, and its parse step carries the result into the output register.
// The per-character multiply-by-ten, add and limit compare are combinational,
// so a word can be accepted every cycle; the output register lets input
// continue while a result waits to be taken, and input stalls only when a
// text-ending word finds that result still held. Configuration is to be
// written while the stream is idle; the block itself does not enforce this.
module decimal_text_to_integer (
	input  logic        clk,
	input  logic        arst_n,
	// Character stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic        s_axis_tuser,   // [0] char_valid
	input  logic        s_axis_tlast,
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [63:0] value, [65:64] status, [71:66] zero
	// Configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_wdata
);

	dtoi_pkg::cfg_t    cfg;
	dtoi_pkg::result_t result;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       cvalid_s1;
	logic       last_s1;
	logic       out_free;
	logic       step;

	logic              out_valid_q;
	dtoi_pkg::result_t out_q;

	dtoi_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dtoi_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step       (step),
		.char_code  (char_s1),
		.char_valid (cvalid_s1),
		.last       (last_s1),
		.result     (result)
	);

	// Handshake: a word ending the text needs room in the output register
	assign out_free      = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1   <= s_axis_tdata;
			cvalid_s1 <= s_axis_tuser;
			last_s1   <= s_axis_tlast;
		end
	end

	// Output register: load on end of text, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_q.status, out_q.value};

`ifndef SYNTHESIS
	// An error result carries zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status != dtoi_pkg::ST_OK)) |-> (out_q.value == 64'd0))
		else $error("error result with nonzero value");

	// A held input word blocks new input
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step) |-> !s_axis_tready)
		else $error("input accepted over a held word");

	// End of text always yields a result word
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_s1) |=> out_valid_q)
		else $error("end of text did not load a result");

	// A pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !(step && last_s1))
		else $error("result overwritten before being taken");
`endif

endmodule

[hw/rtl/dtoi_cfg.sv]
// ----------------------------------------------------------------------------
// dtoi_cfg: configuration registers
// Holds target width and signedness and derives the magnitude limits for
// positive and negative results.
// ----------------------------------------------------------------------------
module dtoi_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [1:0]         cfg_wdata,
	output dtoi_pkg::cfg_t     cfg
);

	logic [1:0] width_select_q;
	logic       is_signed_q;

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_select_q <= dtoi_pkg::WS_32;
			is_signed_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				dtoi_pkg::REG_WIDTH_SELECT: width_select_q <= cfg_wdata;
				dtoi_pkg::REG_IS_SIGNED:    is_signed_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Derive limits
	always_comb begin
		cfg.is_signed = is_signed_q;
		cfg.lim_pos   = dtoi_pkg::mag_limit(width_select_q, is_signed_q, 1'b0);
		cfg.lim_neg   = dtoi_pkg::mag_limit(width_select_q, is_signed_q, 1'b1);
	end

endmodule

[hw/rtl/dtoi_parse.sv]
// ----------------------------------------------------------------------------
// dtoi_parse: parse state machine and accumulator
// Steps the phase and the magnitude by one character per enabled cycle and
// forms the result for an item that ends the text.
// ----------------------------------------------------------------------------
module dtoi_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  dtoi_pkg::cfg_t      cfg,
	input  logic                step,
	input  logic [7:0]          char_code,
	input  logic                char_valid,
	input  logic                last,
	output dtoi_pkg::result_t   result
);

	dtoi_pkg::phase_t ph_q, ph_d;
	logic        neg_q, neg_d;
	logic [63:0] mag_q, mag_d;
	logic [63:0] nmag_q, nmag_d;
	logic        ovf_q, ovf_d;
	logic        seen_q, seen_d;
	logic        junk_q, junk_d;

	logic        c_ws, c_dig, c_plus, c_minus;
	logic [3:0]  dval;
	logic [63:0] lim_cur;
	logic [67:0] mac;
	logic [63:0] nmac;
	logic        mac_over;
	logic        took;
	logic        over;

	// Register state; clear after the item that ends the text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= dtoi_pkg::PH_LEAD;
			neg_q  <= 1'b0;
			mag_q  <= '0;
			nmag_q <= '0;
			ovf_q  <= 1'b0;
			seen_q <= 1'b0;
			junk_q <= 1'b0;
		end else if (step) begin
			if (last) begin
				ph_q   <= dtoi_pkg::PH_LEAD;
				neg_q  <= 1'b0;
				mag_q  <= '0;
				nmag_q <= '0;
				ovf_q  <= 1'b0;
				seen_q <= 1'b0;
				junk_q <= 1'b0;
			end else begin
				ph_q   <= ph_d;
				neg_q  <= neg_d;
				mag_q  <= mag_d;
				nmag_q <= nmag_d;
				ovf_q  <= ovf_d;
				seen_q <= seen_d;
				junk_q <= junk_d;
			end
		end
	end

	// Classify the character and form value * 10 + digit, plain and negated
	always_comb begin
		c_ws     = dtoi_pkg::is_ws(char_code);
		c_dig    = dtoi_pkg::is_dig(char_code);
		c_plus   = (char_code == dtoi_pkg::CH_PLUS);
		c_minus  = (char_code == dtoi_pkg::CH_MINUS);
		dval     = char_code[3:0];
		lim_cur  = neg_q ? cfg.lim_neg : cfg.lim_pos;
		mac      = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + {64'd0, dval};
		nmac     = {nmag_q[60:0], 3'b000} + {nmag_q[62:0], 1'b0} - {60'd0, dval};
		mac_over = (mac > {4'd0, lim_cur});
	end

	// Next phase and accumulator
	always_comb begin
		ph_d   = ph_q;
		neg_d  = neg_q;
		mag_d  = mag_q;
		nmag_d = nmag_q;
		ovf_d  = ovf_q;
		seen_d = seen_q;
		junk_d = junk_q;
		took   = 1'b0;
		if (char_valid) begin
			case (ph_q)
				dtoi_pkg::PH_LEAD, dtoi_pkg::PH_PLUS: begin
					if ((ph_q == dtoi_pkg::PH_LEAD) && c_ws) begin
						ph_d = ph_q;
					end else if ((ph_q == dtoi_pkg::PH_LEAD) && c_plus) begin
						ph_d = dtoi_pkg::PH_PLUS;
					end else if (c_minus) begin
						if (cfg.is_signed) begin
							neg_d = 1'b1;
							ph_d  = dtoi_pkg::PH_MINUS;
						end else begin
							ph_d = dtoi_pkg::PH_BAD;
						end
					end else if (c_dig) begin
						took = 1'b1;
					end else begin
						ph_d = dtoi_pkg::PH_BAD;
					end
				end
				dtoi_pkg::PH_MINUS: begin
					if (c_dig) begin
						took = 1'b1;
					end else begin
						ph_d = dtoi_pkg::PH_BAD;
					end
				end
				dtoi_pkg::PH_DIGIT: begin
					if (c_dig) begin
						took = 1'b1;
					end else if (c_ws) begin
						ph_d = dtoi_pkg::PH_TRAIL;
					end else begin
						ph_d   = dtoi_pkg::PH_JUNK;
						junk_d = 1'b1;
					end
				end
				dtoi_pkg::PH_TRAIL: begin
					if (!c_ws) begin
						ph_d   = dtoi_pkg::PH_JUNK;
						junk_d = 1'b1;
					end
				end
				default: ;
			endcase
		end
		// Accumulate a digit unless the range is already blown
		if (took) begin
			seen_d = 1'b1;
			ph_d   = dtoi_pkg::PH_DIGIT;
			if (!ovf_q) begin
				if (mac_over) begin
					ovf_d = 1'b1;
				end else begin
					mag_d  = mac[63:0];
					nmag_d = nmac;
				end
			end
		end
	end

	// Final status; a freshly accumulated magnitude is already within limit
	always_comb begin
		over = ovf_d || (!took && (mag_q > lim_cur));
		result.value = '0;
		if (!seen_d) begin
			result.status = dtoi_pkg::ST_INVALID;
		end else if (over) begin
			result.status = dtoi_pkg::ST_RANGE;
		end else if (junk_d) begin
			result.status = dtoi_pkg::ST_NOT_INT;
		end else begin
			result.status = dtoi_pkg::ST_OK;
			result.value  = neg_d ? nmag_d : mag_d;
		end
	end

`ifndef SYNTHESIS
	// Parse state starts over after the text ends
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last) |=> (ph_q == dtoi_pkg::PH_LEAD) && (mag_q == 64'd0) && !seen_q)
		else $error("parse state not cleared after end of text");

	// Negated accumulator tracks the magnitude
	a_nmag_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> (nmag_q == (64'd0 - mag_q)))
		else $error("negated magnitude out of step");
`endif

endmodule
